// ----- rtl/ltdc_pkg.sv -----
// shared types, codes and check update for the telegram deframer
package ltdc_pkg;

    localparam logic [7:0]  START_BYTE   = 8'h02;
    localparam logic [7:0]  ADDR_RESET   = 8'h80;
    localparam logic [15:0] CHECK_POLY   = 16'h8005;

    // what the back end does with a queued byte
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_CK_LO = 2'd2;
    localparam logic [1:0] KIND_CK_HI = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } entry_t;

    function automatic logic [15:0] check_step(
        input logic [15:0] crc,
        input logic [7:0]  prev,
        input logic [7:0]  b
    );
        logic [15:0] sh;
        sh = {crc[14:0], 1'b0};
        if (crc[15])
        begin
            sh = sh ^ CHECK_POLY;
        end
        return sh ^ {prev, b};
    endfunction

endpackage

// ----- rtl/ltdc_front.sv -----
// telegram parser: tracks framing and tags each frame byte for the back end
module ltdc_front
    import ltdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_data,
    input  logic         accept,
    input  logic [7:0]   in_byte,
    output logic         push,
    output entry_t       push_entry
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_ADDR   = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_CK_LO  = 3'd5;
    localparam logic [2:0] PH_CK_HI  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  addr_reg;
    logic        emit;
    logic [1:0]  kind;
    logic [15:0] count_inc;
    logic [15:0] len_full;

    assign count_inc = count_reg + 16'd1;
    assign len_full  = {in_byte, len_reg[7:0]};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        kind       = KIND_DATA;
        unique case (phase_reg)
            PH_ADDR:
            begin
                if (in_byte != addr_reg)
                begin
                    if (in_byte == START_BYTE)
                    begin
                        emit       = 1'b1;
                        kind       = KIND_START;
                        phase_next = PH_ADDR;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                emit       = 1'b1;
                len_next   = {8'h00, in_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                emit       = 1'b1;
                len_next   = len_full;
                count_next = 16'd0;
                phase_next = (len_full == 16'd0) ? PH_CK_LO : PH_BODY;
            end
            PH_BODY:
            begin
                emit       = 1'b1;
                count_next = count_inc;
                if (count_inc == len_reg)
                begin
                    phase_next = PH_CK_LO;
                end
            end
            PH_CK_LO:
            begin
                emit       = 1'b1;
                kind       = KIND_CK_LO;
                phase_next = PH_CK_HI;
            end
            PH_CK_HI:
            begin
                emit       = 1'b1;
                kind       = KIND_CK_HI;
                phase_next = PH_HUNT;
            end
            default:
            begin
                if (in_byte == START_BYTE)
                begin
                    emit       = 1'b1;
                    kind       = KIND_START;
                    phase_next = PH_ADDR;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    assign push            = accept & emit;
    assign push_entry.data = in_byte;
    assign push_entry.kind = kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= 16'd0;
            len_reg   <= 16'd0;
            addr_reg  <= ADDR_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                len_reg   <= len_next;
            end
            if (cfg_valid)
            begin
                addr_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- rtl/ltdc_queue.sv -----
// short fifo between parser and check unit
module ltdc_queue
    import ltdc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t         mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

// ----- rtl/ltdc_back.sv -----
// check unit: runs the crc over tagged bytes and drives the output register
module ltdc_back
    import ltdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        not_empty,
    input  entry_t      head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_first,
    output logic        is_last,
    output logic        check_ok,
    output logic [15:0] computed_check
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  prev_reg, prev_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        first_reg, last_reg, ok_reg;
    logic [15:0] chk_reg;
    logic [15:0] chk_next;
    logic        first_next, last_next, ok_next;

    assign pop = not_empty & (~valid_reg | ~out_stall);

    always_comb
    begin
        crc_next   = crc_reg;
        prev_next  = prev_reg;
        ck_lo_next = ck_lo_reg;
        first_next = 1'b0;
        last_next  = 1'b0;
        ok_next    = 1'b0;
        chk_next   = 16'd0;
        unique case (head.kind)
            KIND_START:
            begin
                crc_next   = check_step(16'd0, 8'd0, head.data);
                prev_next  = head.data;
                ck_lo_next = 8'd0;
                first_next = 1'b1;
            end
            KIND_DATA:
            begin
                crc_next  = check_step(crc_reg, prev_reg, head.data);
                prev_next = head.data;
            end
            KIND_CK_LO:
            begin
                ck_lo_next = head.data;
            end
            KIND_CK_HI:
            begin
                last_next = 1'b1;
                ok_next   = ({head.data, ck_lo_reg} == crc_reg);
                chk_next  = crc_reg;
            end
            default:
            begin
                crc_next = crc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= 16'd0;
            prev_reg  <= 8'd0;
            ck_lo_reg <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg   <= crc_next;
                prev_reg  <= prev_next;
                ck_lo_reg <= ck_lo_next;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg  <= head.data;
            first_reg <= first_next;
            last_reg  <= last_next;
            ok_reg    <= ok_next;
            chk_reg   <= chk_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign is_first       = first_reg;
    assign is_last        = last_reg;
    assign check_ok       = ok_reg;
    assign computed_check = chk_reg;

endmodule

// ----- rtl/lidar_telegram_deframer_crc.sv -----
// top level of the telegram deframer with crc check
// Takes one received byte per clock while in_stall is low and passes
// through the bytes of each recognized telegram (start byte, matching
// address, 16-bit length, body, 16-bit check), marking the start byte
// with is_first and the high check byte with is_last, where check_ok and
// computed_check carry the verdict. Bytes outside a telegram are dropped.
// Throughput is one byte per cycle while out_stall is low; a taken byte
// goes into the queue and, once popped, into the output register: the
// parser classifies a byte in the cycle it is taken, the crc unit updates
// its shift-and-xor register once per queued start or data byte, and a
// QUEUE_DEPTH entry fifo between them raises in_stall only once full.
// expected_address may be written through cfg_data at any time the block
// is idle; cfg_ready is always high.
module lidar_telegram_deframer_crc
    import ltdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_first,
    output logic        is_last,
    output logic        check_ok,
    output logic [15:0] computed_check,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   full;
    logic   not_empty;
    entry_t head;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid & ~full;

    ltdc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid & cfg_ready),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .in_byte    (in_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    ltdc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    ltdc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .not_empty      (not_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_first       (is_first),
        .is_last        (is_last),
        .check_ok       (check_ok),
        .computed_check (computed_check)
    );

endmodule

// ----- rtl/ltdc_checker.sv -----
// port-level checks on the telegram deframer, bound to the top level
module ltdc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        is_first,
    input logic        is_last,
    input logic        check_ok,
    input logic [15:0] computed_check
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(is_first) && $stable(is_last) && $stable(computed_check))
        else $error("stalled result changed");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_first |-> !is_last)
        else $error("start byte marked last");

    a_verdict_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> !check_ok && computed_check == 16'd0)
        else $error("verdict outside last byte");

    // a match means the high check byte equals the computed high byte
    a_ok_high_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last && check_ok |-> computed_check[15:8] == out_byte)
        else $error("check_ok with mismatching high byte");

endmodule

bind lidar_telegram_deframer_crc ltdc_checker u_ltdc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .is_first       (is_first),
    .is_last        (is_last),
    .check_ok       (check_ok),
    .computed_check (computed_check)
);

// ----- sim/ltdc_telegram_checker.sv -----
// telegram deframer checker: predicts passed-through bytes from accepted requests and compares
module ltdc_telegram_checker
    import ltdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        is_first,
    input  logic        is_last,
    input  logic        check_ok,
    input  logic [15:0] computed_check,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          pending,
    output int          bytes_taken,
    output int          bytes_predicted,
    output int          bytes_checked,
    output int          telegrams_closed,
    output int          telegrams_good,
    output int          address_writes
);

    typedef enum logic [2:0] {
        SEEK,
        ADDRESS,
        LEN_LO,
        LEN_HI,
        BODY,
        CHK_LO,
        CHK_HI
    } parse_phase_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        ok;
        logic [15:0] chk;
    } frame_byte_t;

    parse_phase_t phase_q;
    logic [15:0]  body_seen;
    logic [15:0]  body_len;
    logic [15:0]  crc_acc;
    logic [7:0]   last_fed;
    logic [7:0]   chk_lo;
    logic [7:0]   addr_cfg;
    frame_byte_t  expected_bytes[$];
    frame_byte_t  oldest;

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("mismatch at output byte %0d: %s expected %h got %h",
                 bytes_checked, what, want, got);
        mismatches++;
    endtask

    task automatic feed_crc(input logic [7:0] b);
        logic [15:0] shifted;
        shifted = {crc_acc[14:0], 1'b0};
        if (crc_acc[15])
        begin
            shifted = shifted ^ CHECK_POLY;
        end
        crc_acc  = shifted ^ {last_fed, b};
        last_fed = b;
    endtask

    task automatic push_expected(input logic [7:0] b, input logic first, input logic last,
                                 input logic ok, input logic [15:0] chk);
        expected_bytes.push_back('{data: b, first: first, last: last, ok: ok, chk: chk});
        bytes_predicted++;
    endtask

    task automatic open_telegram(input logic [7:0] b);
        crc_acc   = '0;
        last_fed  = '0;
        body_seen = '0;
        body_len  = '0;
        chk_lo    = '0;
        feed_crc(b);
        phase_q = ADDRESS;
        push_expected(b, 1'b1, 1'b0, 1'b0, 16'h0000);
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic good;
        case (phase_q)
            ADDRESS:
            begin
                if (b != addr_cfg)
                begin
                    // a start byte in the address slot restarts the telegram
                    if (b == START_BYTE)
                    begin
                        open_telegram(b);
                    end
                    else
                    begin
                        phase_q = SEEK;
                    end
                end
                else
                begin
                    feed_crc(b);
                    phase_q = LEN_LO;
                    push_expected(b, 1'b0, 1'b0, 1'b0, 16'h0000);
                end
            end
            LEN_LO:
            begin
                feed_crc(b);
                body_len = {8'h00, b};
                phase_q  = LEN_HI;
                push_expected(b, 1'b0, 1'b0, 1'b0, 16'h0000);
            end
            LEN_HI:
            begin
                feed_crc(b);
                body_len[15:8] = b;
                body_seen      = '0;
                phase_q        = (body_len == 16'h0000) ? CHK_LO : BODY;
                push_expected(b, 1'b0, 1'b0, 1'b0, 16'h0000);
            end
            BODY:
            begin
                feed_crc(b);
                body_seen = body_seen + 16'h0001;
                if (body_seen == body_len)
                begin
                    phase_q = CHK_LO;
                end
                push_expected(b, 1'b0, 1'b0, 1'b0, 16'h0000);
            end
            CHK_LO:
            begin
                chk_lo  = b;
                phase_q = CHK_HI;
                push_expected(b, 1'b0, 1'b0, 1'b0, 16'h0000);
            end
            CHK_HI:
            begin
                good    = ({b, chk_lo} == crc_acc);
                phase_q = SEEK;
                telegrams_closed++;
                if (good)
                begin
                    telegrams_good++;
                end
                push_expected(b, 1'b0, 1'b1, good, crc_acc);
            end
            default:
            begin
                if (b == START_BYTE)
                begin
                    open_telegram(b);
                end
                else
                begin
                    phase_q = SEEK;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_q          = SEEK;
            body_seen        = '0;
            body_len         = '0;
            crc_acc          = '0;
            last_fed         = '0;
            chk_lo           = '0;
            addr_cfg         = ADDR_RESET;
            expected_bytes   = {};
            mismatches       = 0;
            pending          = 0;
            bytes_taken      = 0;
            bytes_predicted  = 0;
            bytes_checked    = 0;
            telegrams_closed = 0;
            telegrams_good   = 0;
            address_writes   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                addr_cfg = cfg_data;
                address_writes++;
            end
            if (in_valid && !in_stall)
            begin
                predict_byte(in_byte);
                bytes_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected byte", 16'h0000, {8'h00, out_byte});
                end
                else
                begin
                    oldest = expected_bytes.pop_front();
                    if (out_byte != oldest.data)
                        report_mismatch("out_byte", 16'(oldest.data), 16'(out_byte));
                    if (is_first != oldest.first)
                        report_mismatch("is_first", 16'(oldest.first), 16'(is_first));
                    if (is_last != oldest.last)
                        report_mismatch("is_last", 16'(oldest.last), 16'(is_last));
                    if (check_ok != oldest.ok)
                        report_mismatch("check_ok", 16'(oldest.ok), 16'(check_ok));
                    if (computed_check != oldest.chk)
                        report_mismatch("computed_check", oldest.chk, computed_check);
                end
                bytes_checked++;
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// ----- sim/tb_lidar_telegram_deframer_crc.sv -----
// testbench top for the telegram deframer: stimulus, idling and verdict
module tb_lidar_telegram_deframer_crc;
    import ltdc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 12;
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_START   = 1;
    localparam int FILL_EXTREME = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        is_first;
    logic        is_last;
    logic        check_ok;
    logic [15:0] computed_check;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;

    int mismatches;
    int pending;
    int bytes_taken;
    int bytes_predicted;
    int bytes_checked;
    int telegrams_closed;
    int telegrams_good;
    int address_writes;
    int cycle_count = 0;

    bit         send_busy = 1'b0;
    bit         recv_busy = 1'b0;
    logic [7:0] cur_addr = ADDR_RESET;

    lidar_telegram_deframer_crc i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_first       (is_first),
        .is_last        (is_last),
        .check_ok       (check_ok),
        .computed_check (computed_check),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    ltdc_telegram_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .is_first         (is_first),
        .is_last          (is_last),
        .check_ok         (check_ok),
        .computed_check   (computed_check),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pending          (pending),
        .bytes_taken      (bytes_taken),
        .bytes_predicted  (bytes_predicted),
        .bytes_checked    (bytes_checked),
        .telegrams_closed (telegrams_closed),
        .telegrams_good   (telegrams_good),
        .address_writes   (address_writes)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_lidar_telegram_deframer_crc NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] telegram_crc(input logic [7:0] bytes[$]);
        logic [15:0] acc;
        logic [7:0]  prior;
        acc   = '0;
        prior = '0;
        foreach (bytes[k])
        begin
            acc   = {acc[14:0], 1'b0} ^ (acc[15] ? CHECK_POLY : 16'h0000) ^ {prior, bytes[k]};
            prior = bytes[k];
        end
        return acc;
    endfunction

    // one request on the byte channel, called and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_busy ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_telegram(input logic [7:0] addr, input logic [15:0] len,
                                 input bit spoil, input int fill);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        logic [7:0]  b;
        frame.push_back(START_BYTE);
        frame.push_back(addr);
        frame.push_back(len[7:0]);
        frame.push_back(len[15:8]);
        for (int i = 0; i < int'(len); i++)
        begin
            case (fill)
                FILL_START:   b = START_BYTE;
                FILL_EXTREME: b = i[0] ? 8'h00 : 8'hFF;
                default:      b = ($urandom_range(0, 7) == 0) ? START_BYTE
                                                               : 8'($urandom_range(0, 255));
            endcase
            frame.push_back(b);
        end
        crc = telegram_crc(frame);
        if (spoil)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        foreach (frame[k])
        begin
            send_byte(frame[k]);
        end
    endtask

    // hold off until every predicted byte is out and the pipeline has drained
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_address(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_addr = v;
    endtask

    // receiver side: random stall ahead of each output request while recv_busy is set
    initial
    begin
        int w;
        forever
        begin
            w = recv_busy ? $urandom_range(0, 19) : 0;
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [7:0]  settings[6];
        logic [7:0]  bad;
        logic [15:0] len;
        int          target;
        int          pick;
        int          len_pick;
        int          n;
        bit          base_send;
        bit          base_recv;

        settings = '{8'h00, 8'hFF, START_BYTE, 8'($urandom_range(0, 255)), ADDR_RESET,
                     8'($urandom_range(0, 255))};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset address
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(8'h55);
        send_byte(START_BYTE);
        send_telegram(cur_addr, 16'h0000, 1'b0, FILL_RANDOM);
        send_telegram(cur_addr, 16'h0001, 1'b1, FILL_START);
        send_telegram(cur_addr, 16'h0002, 1'b0, FILL_EXTREME);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_address(settings[p]);
            base_send = (p % 4 == 0) || (p % 4 == 2);
            base_recv = (p % 4 == 0) || (p % 4 == 3);
            target    = bytes_predicted + 85;
            while (bytes_predicted < target)
            begin
                send_busy = base_send && ($urandom_range(0, 4) != 0);
                recv_busy = base_recv && ($urandom_range(0, 4) != 0);
                pick      = $urandom_range(0, 19);
                len_pick  = $urandom_range(0, 19);
                if (len_pick < 14)
                    len = 16'($urandom_range(0, 8));
                else if (len_pick < 18)
                    len = 16'($urandom_range(9, 40));
                else
                    len = 16'($urandom_range(41, 300));
                if (pick < 12)
                begin
                    send_telegram(cur_addr, len, 1'b0, FILL_RANDOM);
                end
                else if (pick < 14)
                begin
                    send_telegram(cur_addr, len, 1'b1, FILL_RANDOM);
                end
                else if (pick < 16)
                begin
                    // line noise while hunting
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        do
                            bad = 8'($urandom_range(0, 255));
                        while (bad == START_BYTE);
                        send_byte(bad);
                    end
                end
                else if (pick < 18)
                begin
                    do
                        bad = 8'($urandom_range(0, 255));
                    while (bad == cur_addr || bad == START_BYTE);
                    send_byte(START_BYTE);
                    send_byte(bad);
                end
                else
                begin
                    // stray start byte right before a telegram restarts it
                    if (cur_addr != START_BYTE)
                    begin
                        send_byte(START_BYTE);
                    end
                    send_telegram(cur_addr, len, 1'b0, FILL_RANDOM);
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    drain();
                end
            end
        end

        drain();

        $display("covered %0d input bytes, %0d output bytes checked, %0d telegrams (%0d good)",
                 bytes_taken, bytes_checked, telegrams_closed, telegrams_good);
        $display("%0d address settings, noise, aborted headers and random idling on both sides",
                 address_writes);
        if (mismatches == 0)
        begin
            $display("tb_lidar_telegram_deframer_crc OK");
        end
        else
        begin
            $display("tb_lidar_telegram_deframer_crc NOT OK");
        end
        $finish;
    end

endmodule
